[hdl/held_karp_tour_solver_unit_macros.svh]
`ifndef HELD_KARP_TOUR_SOLVER_UNIT_MACROS_SVH
`define HELD_KARP_TOUR_SOLVER_UNIT_MACROS_SVH

// same-cycle implication
`define HKTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HKTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/hkts_pkg.sv]
`default_nettype none
package hkts_pkg;

  localparam int MAX_CITIES = 12;
  localparam int COORD_BITS = 16;
  localparam int COST_BITS  = 24;
  localparam int CITY_W     = 4;
  localparam int LEN_W      = 24;
  localparam int DIST_W     = COORD_BITS + 1;
  localparam int SUMSQ_W    = 2 * COORD_BITS + 2;
  localparam int SQRT_ITER  = SUMSQ_W / 2;
  localparam int PC_DEPTH   = (1 << MAX_CITIES) * MAX_CITIES;
  localparam int PC_AW      = $clog2(PC_DEPTH);
  localparam int DT_DEPTH   = MAX_CITIES * MAX_CITIES;
  localparam int DT_AW      = $clog2(DT_DEPTH);

  typedef logic [CITY_W-1:0]     city_t;
  typedef logic [COST_BITS-1:0]  cost_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [MAX_CITIES-1:0] subset_t;

  localparam cost_t COST_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [CITY_W-1:0]             city_slot;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
  } in_item_t;

  typedef struct packed {
    logic [CITY_W-1:0] tour_position;
    logic [CITY_W-1:0] city_at_position;
    logic [LEN_W-1:0]  tour_length;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } coord_t;

  typedef struct packed {
    cost_t cost;
    logic  take;
  } pick_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CRD_A, S_CRD_B, S_SQ, S_SQRT_GO, S_SQRT_WAIT,
    S_DP_J, S_DP_K, S_DP_ACC, S_DP_WR,
    S_CL_RD, S_CL_ACC, S_BT_J, S_BT_ACC, S_BT_WR, S_OUT
  } state_t;

  function automatic logic [PC_AW-1:0] pc_addr(subset_t s, city_t c);
    return PC_AW'(s) * PC_AW'(MAX_CITIES) + PC_AW'(c);
  endfunction

  function automatic logic [DT_AW-1:0] dt_addr(city_t a, city_t b);
    return DT_AW'(a) * DT_AW'(MAX_CITIES) + DT_AW'(b);
  endfunction

endpackage
`default_nettype wire

[hdl/hkts_sqrt.sv]
`default_nettype none
module hkts_sqrt (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [hkts_pkg::SUMSQ_W-1:0]    radicand,
  output logic                                 done,
  output hkts_pkg::dist_t                      root
);

  localparam int RW = hkts_pkg::DIST_W + 3;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [4:0]                     cnt_r, cnt_nxt;
  logic [hkts_pkg::SUMSQ_W-1:0]   rad_r, rad_nxt;
  logic [RW-1:0]                  rem_r, rem_nxt;
  hkts_pkg::dist_t                root_r, root_nxt;
  hkts_pkg::dist_t                res_r, res_nxt;
  logic [RW-1:0]                  rem_sh;
  logic [RW-1:0]                  trial;
  logic [hkts_pkg::DIST_W:0]      rounded;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    res_nxt  = res_r;
    rem_sh   = {rem_r[RW-3:0], rad_r[hkts_pkg::SUMSQ_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rounded  = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(hkts_pkg::SQRT_ITER);
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[hkts_pkg::DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[hkts_pkg::DIST_W-2:0], 1'b0};
      end
      rad_nxt = rad_r << 2;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        rounded  = {1'b0, root_nxt} +
                   (hkts_pkg::DIST_W+1)'(rem_nxt > RW'(root_nxt));
        res_nxt  = rounded[hkts_pkg::DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign root = res_r;

endmodule
`default_nettype wire

[hdl/hkts_addcmp.sv]
`default_nettype none
module hkts_addcmp (
  input  wire hkts_pkg::cost_t base,
  input  wire hkts_pkg::dist_t leg,
  input  wire hkts_pkg::cost_t best,
  input  wire logic            have,
  output hkts_pkg::pick_t      res
);

  logic [hkts_pkg::COST_BITS:0] sum;
  hkts_pkg::cost_t              sat;

  always_comb begin
    sum      = {1'b0, base} + (hkts_pkg::COST_BITS+1)'(leg);
    sat      = sum[hkts_pkg::COST_BITS] ? hkts_pkg::COST_MAX : sum[hkts_pkg::COST_BITS-1:0];
    res.cost = sat;
    res.take = !have || (sat < best);
  end

endmodule
`default_nettype wire

[hdl/held_karp_tour_solver_unit.sv]
// Load item: accepted while idle, no result.
// Solve item: distance table, then the subset table (one saturating
// add/compare per candidate), closing and backtrack; then n results.
// Throughput: one item at a time; not ready from solve until the last result.
// Reset: synchronous active-low rst_n; city_count returns to 1, stores keep data.
`default_nettype none
`include "held_karp_tour_solver_unit_macros.svh"
module held_karp_tour_solver_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hkts_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hkts_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [3:0]          cfg_data
);

  localparam int PW = 2 * hkts_pkg::COORD_BITS;

  hkts_pkg::state_t  state_r, state_nxt;
  logic [3:0]        cnt_r;
  hkts_pkg::city_t   n_r, n_nxt;
  hkts_pkg::city_t   k_r, k_nxt, j_r, j_nxt, pos_r, pos_nxt;
  hkts_pkg::city_t   next_r, next_nxt, pick_r, pick_nxt, out_pos_r, out_pos_nxt;
  hkts_pkg::subset_t s_r, s_nxt, back_r, back_nxt;
  hkts_pkg::cost_t   best_r, best_nxt, len_r, len_nxt;
  logic              have_r, have_nxt;
  logic [1:0]        c_r, c_nxt;
  hkts_pkg::coord_t  a_r, a_nxt;
  logic [hkts_pkg::SUMSQ_W-1:0] acc_r, acc_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;

  hkts_pkg::coord_t  crd_mem [hkts_pkg::MAX_CITIES];
  hkts_pkg::coord_t  crd_q_r;
  hkts_pkg::city_t   crd_ra;
  logic              crd_we;

  hkts_pkg::dist_t   dt_mem [hkts_pkg::DT_DEPTH];
  hkts_pkg::dist_t   dt_q_r;
  logic [hkts_pkg::DT_AW-1:0] dt_ra, dt_wa;
  logic              dt_we;

  hkts_pkg::cost_t   pc_mem [hkts_pkg::PC_DEPTH];
  hkts_pkg::cost_t   pc_q_r, pc_wd;
  logic [hkts_pkg::PC_AW-1:0] pc_ra, pc_wa;
  logic              pc_we;

  hkts_pkg::city_t   tour_r [hkts_pkg::MAX_CITIES];
  hkts_pkg::city_t   tour_wa, tour_wd;
  logic              tour_we;

  logic              sq_start, sq_done;
  hkts_pkg::dist_t   sq_root;
  hkts_pkg::pick_t   unit_res;

  hkts_pkg::subset_t full, prev, lc_bit;
  hkts_pkg::city_t   nm1, lc;
  hkts_pkg::cost_t   lb;
  logic signed [hkts_pkg::COORD_BITS-1:0] ca, cb;
  logic signed [hkts_pkg::COORD_BITS:0]   dif;
  logic [hkts_pkg::COORD_BITS:0]          mag;

  hkts_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  hkts_addcmp u_addcmp (
    .base (pc_q_r),
    .leg  (dt_q_r),
    .best (best_r),
    .have (have_r),
    .res  (unit_res)
  );

  assign nm1 = n_r - 4'd1;

  always_comb begin
    for (int b = 0; b < hkts_pkg::MAX_CITIES; b++) begin
      full[b] = (b < int'(n_r));
    end
  end

  assign prev   = s_r ^ (hkts_pkg::subset_t'(1) << j_r);
  assign lc     = unit_res.take ? k_r : pick_r;
  assign lb     = unit_res.take ? unit_res.cost : best_r;
  assign lc_bit = hkts_pkg::subset_t'(1) << lc;

  always_comb begin
    unique case (c_r)
      2'd0:    begin ca = a_r.x; cb = crd_q_r.x; end
      2'd1:    begin ca = a_r.y; cb = crd_q_r.y; end
      default: begin ca = a_r.z; cb = crd_q_r.z; end
    endcase
    dif = {ca[hkts_pkg::COORD_BITS-1], ca} - {cb[hkts_pkg::COORD_BITS-1], cb};
    mag = dif[hkts_pkg::COORD_BITS] ? (~dif + 1'b1) : dif;
  end

  assign in_ready  = (state_r == hkts_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign crd_we    = in_valid && in_ready && (in_data.command == hkts_pkg::CMD_LOAD) &&
                     (int'(in_data.city_slot) < hkts_pkg::MAX_CITIES);

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    pos_nxt     = pos_r;
    next_nxt    = next_r;
    pick_nxt    = pick_r;
    out_pos_nxt = out_pos_r;
    s_nxt       = s_r;
    back_nxt    = back_r;
    best_nxt    = best_r;
    len_nxt     = len_r;
    have_nxt    = have_r;
    c_nxt       = c_r;
    a_nxt       = a_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    crd_ra      = j_r;
    dt_ra       = hkts_pkg::dt_addr(k_r, j_r);
    dt_wa       = hkts_pkg::dt_addr(k_r, j_r);
    dt_we       = 1'b0;
    pc_ra       = hkts_pkg::pc_addr(prev, k_r);
    pc_wa       = hkts_pkg::pc_addr(s_r, j_r);
    pc_wd       = best_r;
    pc_we       = 1'b0;
    tour_we     = 1'b0;
    tour_wa     = '0;
    tour_wd     = '0;
    sq_start    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      hkts_pkg::S_IDLE: begin
        if (in_valid && in_data.command == hkts_pkg::CMD_SOLVE) begin
          if (cnt_r == 4'd0) begin
            n_nxt = 4'd1;
          end else if (int'(cnt_r) > hkts_pkg::MAX_CITIES) begin
            n_nxt = 4'(hkts_pkg::MAX_CITIES);
          end else begin
            n_nxt = cnt_r;
          end
          k_nxt     = '0;
          j_nxt     = '0;
          tour_we   = 1'b1;
          state_nxt = hkts_pkg::S_CRD_A;
        end
      end
      hkts_pkg::S_CRD_A: begin
        crd_ra    = k_r;
        state_nxt = hkts_pkg::S_CRD_B;
      end
      hkts_pkg::S_CRD_B: begin
        a_nxt     = crd_q_r;
        acc_nxt   = '0;
        c_nxt     = '0;
        state_nxt = hkts_pkg::S_SQ;
      end
      hkts_pkg::S_SQ: begin
        if (c_r != 2'd3) begin
          prod_nxt = mag[hkts_pkg::COORD_BITS-1:0] * mag[hkts_pkg::COORD_BITS-1:0];
        end
        if (c_r != 2'd0) begin
          acc_nxt = acc_r + hkts_pkg::SUMSQ_W'(prod_r);
        end
        c_nxt = c_r + 2'd1;
        if (c_r == 2'd3) begin
          state_nxt = hkts_pkg::S_SQRT_GO;
        end
      end
      hkts_pkg::S_SQRT_GO: begin
        sq_start  = 1'b1;
        state_nxt = hkts_pkg::S_SQRT_WAIT;
      end
      hkts_pkg::S_SQRT_WAIT: begin
        if (sq_done) begin
          dt_we     = 1'b1;
          state_nxt = hkts_pkg::S_CRD_A;
          if (j_r == nm1) begin
            j_nxt = '0;
            if (k_r == nm1) begin
              s_nxt     = hkts_pkg::subset_t'(1);
              state_nxt = hkts_pkg::S_DP_J;
            end else begin
              k_nxt = k_r + 4'd1;
            end
          end else begin
            j_nxt = j_r + 4'd1;
          end
        end
      end
      hkts_pkg::S_DP_J, hkts_pkg::S_DP_WR: begin
        if (state_r == hkts_pkg::S_DP_WR) begin
          pc_we = 1'b1;
          if (s_r == hkts_pkg::subset_t'(1) && j_r == '0) begin
            pc_wd = '0;
          end
        end
        if (state_r == hkts_pkg::S_DP_J && s_r[j_r]) begin
          best_nxt  = hkts_pkg::COST_MAX;
          have_nxt  = 1'b1;
          k_nxt     = '0;
          state_nxt = hkts_pkg::S_DP_K;
        end else if (j_r == nm1) begin
          if (s_r == full) begin
            k_nxt     = '0;
            have_nxt  = 1'b0;
            best_nxt  = hkts_pkg::COST_MAX;
            pick_nxt  = '0;
            state_nxt = hkts_pkg::S_CL_RD;
          end else begin
            s_nxt     = s_r + 1'b1;
            j_nxt     = '0;
            state_nxt = hkts_pkg::S_DP_J;
          end
        end else begin
          j_nxt     = j_r + 4'd1;
          state_nxt = hkts_pkg::S_DP_J;
        end
      end
      hkts_pkg::S_DP_K: begin
        if (prev[k_r]) begin
          state_nxt = hkts_pkg::S_DP_ACC;
        end else if (k_r == nm1) begin
          state_nxt = hkts_pkg::S_DP_WR;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      hkts_pkg::S_DP_ACC: begin
        if (unit_res.take) begin
          best_nxt = unit_res.cost;
        end
        if (k_r == nm1) begin
          state_nxt = hkts_pkg::S_DP_WR;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = hkts_pkg::S_DP_K;
        end
      end
      hkts_pkg::S_CL_RD: begin
        pc_ra     = hkts_pkg::pc_addr(full, k_r);
        dt_ra     = hkts_pkg::dt_addr(k_r, '0);
        state_nxt = hkts_pkg::S_CL_ACC;
      end
      hkts_pkg::S_CL_ACC: begin
        best_nxt = lb;
        pick_nxt = lc;
        have_nxt = 1'b1;
        if (k_r == nm1) begin
          len_nxt  = lb;
          tour_we  = 1'b1;
          tour_wa  = nm1;
          tour_wd  = lc;
          back_nxt = full & ~lc_bit;
          next_nxt = lc;
          if (n_r >= 4'd3) begin
            pos_nxt   = n_r - 4'd2;
            j_nxt     = nm1;
            have_nxt  = 1'b0;
            best_nxt  = hkts_pkg::COST_MAX;
            pick_nxt  = n_r - 4'd2;
            state_nxt = hkts_pkg::S_BT_J;
          end else begin
            out_pos_nxt = '0;
            state_nxt   = hkts_pkg::S_OUT;
          end
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = hkts_pkg::S_CL_RD;
        end
      end
      hkts_pkg::S_BT_J: begin
        pc_ra = hkts_pkg::pc_addr(back_r, j_r);
        dt_ra = hkts_pkg::dt_addr(j_r, next_r);
        if (back_r[j_r]) begin
          state_nxt = hkts_pkg::S_BT_ACC;
        end else if (j_r == 4'd1) begin
          state_nxt = hkts_pkg::S_BT_WR;
        end else begin
          j_nxt = j_r - 4'd1;
        end
      end
      hkts_pkg::S_BT_ACC: begin
        have_nxt = 1'b1;
        if (unit_res.take) begin
          best_nxt = unit_res.cost;
          pick_nxt = j_r;
        end
        if (j_r == 4'd1) begin
          state_nxt = hkts_pkg::S_BT_WR;
        end else begin
          j_nxt     = j_r - 4'd1;
          state_nxt = hkts_pkg::S_BT_J;
        end
      end
      hkts_pkg::S_BT_WR: begin
        tour_we  = 1'b1;
        tour_wa  = pos_r;
        tour_wd  = pick_r;
        back_nxt = back_r & ~(hkts_pkg::subset_t'(1) << pick_r);
        next_nxt = pick_r;
        if (pos_r == 4'd1) begin
          out_pos_nxt = '0;
          state_nxt   = hkts_pkg::S_OUT;
        end else begin
          pos_nxt   = pos_r - 4'd1;
          j_nxt     = nm1;
          have_nxt  = 1'b0;
          best_nxt  = hkts_pkg::COST_MAX;
          pick_nxt  = pos_r - 4'd1;
          state_nxt = hkts_pkg::S_BT_J;
        end
      end
      hkts_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_pos_r == nm1) begin
            state_nxt = hkts_pkg::S_IDLE;
          end else begin
            out_pos_nxt = out_pos_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = hkts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hkts_pkg::S_IDLE;
      cnt_r   <= 4'd1;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= cfg_data;
      end
    end
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    pos_r     <= pos_nxt;
    next_r    <= next_nxt;
    pick_r    <= pick_nxt;
    out_pos_r <= out_pos_nxt;
    s_r       <= s_nxt;
    back_r    <= back_nxt;
    best_r    <= best_nxt;
    len_r     <= len_nxt;
    have_r    <= have_nxt;
    c_r       <= c_nxt;
    a_r       <= a_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (crd_we) begin
      crd_mem[in_data.city_slot] <= '{x: in_data.coord_x, y: in_data.coord_y,
                                      z: in_data.coord_z};
    end
    crd_q_r <= crd_mem[crd_ra];
  end

  always_ff @(posedge clk) begin
    if (dt_we) begin
      dt_mem[dt_wa] <= sq_root;
    end
    dt_q_r <= dt_mem[dt_ra];
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem[pc_wa] <= pc_wd;
    end
    pc_q_r <= pc_mem[pc_ra];
  end

  always_ff @(posedge clk) begin
    if (tour_we) begin
      tour_r[tour_wa] <= tour_wd;
    end
  end

  assign out_data.tour_position    = out_pos_r;
  assign out_data.city_at_position = tour_r[out_pos_r];
  assign out_data.tour_length      = hkts_pkg::LEN_W'(len_r);
  assign out_data.last             = (out_pos_r == nm1);

  `HKTS_ASSERT_IMP(a_out_blocks_in, out_valid, !in_ready, "result pending while input ready")
  `HKTS_ASSERT_NXT(a_solve_busy, in_valid && in_ready && in_data.command == hkts_pkg::CMD_SOLVE, !in_ready, "solve item did not start")
  `HKTS_ASSERT_NXT(a_out_continues, out_valid && out_ready && !out_data.last, out_valid, "tour results broke off early")
  `HKTS_ASSERT_IMP(a_sqrt_expected, sq_done, state_r == hkts_pkg::S_SQRT_WAIT, "root returned outside wait state")

endmodule
`default_nettype wire

[dv/held_karp_tour_solver_unit_test.sv]
`default_nettype none
module held_karp_tour_solver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned COST_TOP = (64'd1 << hkts_pkg::COST_BITS) - 1;
  localparam int STALL_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hkts_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hkts_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = 4'd1;

  held_karp_tour_solver_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  hkts_pkg::in_item_t pending_items[$];
  hkts_pkg::out_item_t expected_stops[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  logic in_fire = 1'b0;

  // predictor state
  int city_xyz[hkts_pkg::MAX_CITIES][3];
  logic [3:0] city_count_reg = 4'd1;
  longint unsigned leg[hkts_pkg::MAX_CITIES][hkts_pkg::MAX_CITIES];
  longint unsigned subset_cost[(1 << hkts_pkg::MAX_CITIES) * hkts_pkg::MAX_CITIES];

  function automatic longint unsigned cost_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > COST_TOP) ? COST_TOP : s;
  endfunction

  function automatic longint unsigned rounded_root(longint unsigned v);
    longint unsigned r, bit_v, s;
    r = 0;
    s = v;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v >>= 2;
    while (bit_v != 0) begin
      if (s >= r + bit_v) begin
        s -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    if (v > r * r + r) r++;
    return r;
  endfunction

  function automatic void queue_item(hkts_pkg::in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  task automatic predict_tour();
    int n, pos, last_city, pick, nxt;
    int unsigned full, back, prev;
    longint unsigned best_len, bl, c, sq, d;
    bit have;
    int order[hkts_pkg::MAX_CITIES];
    hkts_pkg::out_item_t o;
    n = int'(city_count_reg);
    if (n < 1) n = 1;
    if (n > hkts_pkg::MAX_CITIES) n = hkts_pkg::MAX_CITIES;
    full = (1 << n) - 1;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        sq = 0;
        for (int a = 0; a < 3; a++) begin
          d = (city_xyz[i][a] >= city_xyz[j][a]) ? city_xyz[i][a] - city_xyz[j][a]
                                                 : city_xyz[j][a] - city_xyz[i][a];
          sq += d * d;
        end
        leg[i][j] = rounded_root(sq);
      end
    for (int s = 0; s <= full; s++)
      for (int j = 0; j < n; j++) subset_cost[s * hkts_pkg::MAX_CITIES + j] = COST_TOP;
    subset_cost[hkts_pkg::MAX_CITIES] = 0;
    for (int s = 1; s <= full; s++)
      for (int j = 0; j < n; j++) begin
        if (((s >> j) & 1) == 0) continue;
        prev = s ^ (1 << j);
        for (int k = 0; k < n; k++) begin
          if (((prev >> k) & 1) == 0) continue;
          c = cost_add(subset_cost[prev * hkts_pkg::MAX_CITIES + k], leg[k][j]);
          if (c < subset_cost[s * hkts_pkg::MAX_CITIES + j])
            subset_cost[s * hkts_pkg::MAX_CITIES + j] = c;
        end
      end
    for (int i = 0; i < n; i++) order[i] = i;
    best_len = COST_TOP;
    last_city = 0;
    have = 0;
    for (int i = 0; i < n; i++) begin
      c = cost_add(subset_cost[full * hkts_pkg::MAX_CITIES + i], leg[i][0]);
      if (!have || c < best_len) begin
        best_len = c;
        last_city = i;
        have = 1;
      end
    end
    order[n-1] = last_city;
    back = full & ~(1 << last_city);
    for (pos = n - 2; pos >= 1; pos--) begin
      bl = COST_TOP;
      pick = order[pos];
      nxt = order[pos+1];
      have = 0;
      for (int j = n - 1; j > 0; j--) begin
        if (((back >> j) & 1) == 0) continue;
        c = cost_add(subset_cost[back * hkts_pkg::MAX_CITIES + j], leg[j][nxt]);
        if (!have || c < bl) begin
          bl = c;
          pick = j;
          have = 1;
        end
      end
      order[pos] = pick;
      back &= ~(1 << pick);
    end
    if (best_len > 64'hFFFFFF) best_len = 64'hFFFFFF;
    for (pos = 0; pos < n; pos++) begin
      o.tour_position = pos[3:0];
      o.city_at_position = order[pos][3:0];
      o.tour_length = best_len[23:0];
      o.last = (pos == n - 1);
      expected_stops.insert(expected_stops.size(), o);
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_data <= pending_items.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and checker
  always @(posedge clk) begin
    hkts_pkg::out_item_t e;
    in_fire <= in_valid && in_ready && rst_n;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_data.command == hkts_pkg::CMD_LOAD) begin
          if (in_data.city_slot < hkts_pkg::MAX_CITIES) begin
            city_xyz[in_data.city_slot][0] = in_data.coord_x;
            city_xyz[in_data.city_slot][1] = in_data.coord_y;
            city_xyz[in_data.city_slot][2] = in_data.coord_z;
          end
        end else begin
          predict_tour();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_stops.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", out_data);
        end else begin
          e = expected_stops.pop_front();
          if (out_data.tour_position !== e.tour_position ||
              out_data.city_at_position !== e.city_at_position ||
              out_data.tour_length !== e.tour_length || out_data.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_stops.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_city_count(logic [3:0] v);
    wait_drained();
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    city_count_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic hkts_pkg::in_item_t city_load(int slot, int x, int y, int z);
    hkts_pkg::in_item_t it;
    it.command = hkts_pkg::CMD_LOAD;
    it.city_slot = slot[3:0];
    it.coord_x = x[15:0];
    it.coord_y = y[15:0];
    it.coord_z = z[15:0];
    return it;
  endfunction

  function automatic hkts_pkg::in_item_t solve_item();
    hkts_pkg::in_item_t it;
    it = city_load($urandom_range(15), $urandom, $urandom, $urandom);
    it.command = hkts_pkg::CMD_SOLVE;
    return it;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_city_count(4'd1);
    queue_item(city_load(0, -32768, -32768, -32768));
    queue_item(city_load(1, 32767, 32767, 32767));
    queue_item(city_load(2, 0, 0, 0));
    queue_item(city_load(3, -1, 1, -32768));
    for (int s = 4; s < hkts_pkg::MAX_CITIES; s++)
      queue_item(city_load(s, $urandom, $urandom, $urandom));
    queue_item(city_load(12, 5, 5, 5));
    queue_item(city_load(15, -5, -5, -5));
    queue_item(solve_item());
    write_city_count(4'd2);
    queue_item(solve_item());
    write_city_count(4'd0);
    queue_item(solve_item());
    write_city_count(4'd12);
    queue_item(solve_item());
    write_city_count(4'd13);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 17 : 0;
      for (int r = 0; r < 4; r++) begin
        write_city_count(4'($urandom_range(6)));
        for (int i = 0; i < 5; i++) begin
          queue_item(city_load($urandom_range(15), $urandom, $urandom, $urandom));
          if ($urandom_range(3) == 0) queue_item(solve_item());
        end
        queue_item(solve_item());
      end
    end
    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_stops.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
